>>> sv/gld_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gld_pkg: shared types and constants for the GIF LZW decoder
// Request kinds, status codes, the front-to-back command struct and the
// decoder sequencer states.
// ----------------------------------------------------------------------------
package gld_pkg;

    localparam int MAX_CODE_BITS_DEF = 12;
    localparam int ACC_BITS_DEF      = 32;
    localparam int STACK_DEPTH       = 4096;
    localparam int STACK_AW          = 12;

    typedef enum logic [1:0] {
        REQ_FEED    = 2'd0,
        REQ_PULL    = 2'd1,
        REQ_RESTART = 2'd2,
        REQ_BAD     = 2'd3
    } t_req;

    typedef enum logic [2:0] {
        ST_PIXEL = 3'd0,
        ST_NEED  = 3'd1,
        ST_END   = 3'd2,
        ST_ERR   = 3'd3,
        ST_OK    = 3'd4,
        ST_FULL  = 3'd5
    } t_status;

    // request handed from the front part to the back part
    typedef struct packed {
        t_req       kind;
        logic [7:0] data;
        logic       eod;
    } t_cmd;

    typedef enum logic [2:0] {
        S_IDLE,
        S_DECODE,
        S_WALK,
        S_POP,
        S_READ,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

>>> sv/gld_front.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gld_front: request intake
// Accepts stream requests into a two-entry queue and presents them to the
// decode engine as classified commands.
// ----------------------------------------------------------------------------
module gld_front (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_valid,
    output logic            o_ready,
    input  wire [1:0]       i_kind,
    input  wire [7:0]       i_data,
    input  wire             i_eod,
    output logic            o_cmd_valid,
    input  wire             i_cmd_take,
    output gld_pkg::t_cmd   o_cmd
);
    import gld_pkg::*;

    t_cmd       r_q [2];
    logic       r_wp, r_rp;
    logic [1:0] r_cnt;
    logic       push, pop;

    assign o_ready     = (r_cnt != 2'd2);
    assign o_cmd_valid = (r_cnt != 2'd0);
    assign o_cmd       = r_q[r_rp];
    assign push        = i_valid && o_ready;
    assign pop         = i_cmd_take && o_cmd_valid;

    // queue storage
    always_ff @(posedge i_clk) begin
        if (push) begin
            r_q[r_wp] <= '{kind: t_req'(i_kind), data: i_data, eod: i_eod};
        end
    end

    // pointers and fill
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (push) r_wp <= ~r_wp;
            if (pop)  r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, push} - {1'b0, pop};
        end
    end

endmodule
`default_nettype wire

>>> sv/gld_back.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// gld_back: LZW decode engine
// Bit accumulator, code table memories, output stack and the sequencer that
// extracts codes, walks prefix chains and pops pixels into a result register.
// ----------------------------------------------------------------------------
module gld_back #(
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
    parameter int ACC_BITS      = gld_pkg::ACC_BITS_DEF
) (
    input  wire             i_clk,
    input  wire             i_rst_n,
    input  wire             i_cmd_valid,
    output logic            o_cmd_take,
    input  gld_pkg::t_cmd   i_cmd,
    input  wire [3:0]       i_min_code_size,
    output logic            o_valid,
    input  wire             i_ready,
    output logic [7:0]      o_pixel,
    output logic [2:0]      o_status
);
    import gld_pkg::*;

    localparam int TSIZE = 1 << MAX_CODE_BITS;
    localparam int CW    = MAX_CODE_BITS;
    localparam int HW    = $clog2(ACC_BITS + 1);

    // memories
    logic [CW-1:0]       m_prefix [TSIZE];
    logic [7:0]          m_suffix [TSIZE];
    logic [7:0]          m_stack  [STACK_DEPTH];

    t_state              r_state, n_state;
    logic [ACC_BITS-1:0] r_acc;
    logic [HW-1:0]       r_held;
    logic [3:0]          r_cw;
    logic [CW:0]         r_free;
    logic [CW:0]         r_limit;
    logic [CW-1:0]       r_first, r_prev, r_code, r_c;
    logic                r_await, r_fin, r_halt;
    logic [STACK_AW:0]   r_sp;
    logic                r_valid;
    logic [7:0]          r_pix;
    logic [2:0]          r_st;
    logic [CW-1:0]       r_pre_rd;
    logic [7:0]          r_suf_rd, r_stk_rd;

    logic [3:0]          root;
    logic [CW:0]         clr;
    logic [CW-1:0]       code_now;
    logic                have_bits;
    logic                out_free;
    logic                finish;
    t_status             fin_st;
    logic [7:0]          fin_pix;

    always_comb begin
        root = i_min_code_size;
        if (root < 4'd2) root = 4'd2;
        if (root > 4'd8) root = 4'd8;
    end
    assign clr       = (CW+1)'(1) << root;
    assign have_bits = (r_held >= HW'(r_cw));
    assign code_now  = CW'(r_acc & ACC_BITS'((ACC_BITS'(1) << r_cw) - 1));
    assign out_free  = !r_valid || i_ready;
    assign o_valid   = r_valid;
    assign o_pixel   = r_pix;
    assign o_status  = r_st;
    assign o_cmd_take = (r_state == S_IDLE) && i_cmd_valid && out_free;

    // table and stack memory reads, registered
    always_ff @(posedge i_clk) begin
        r_pre_rd <= m_prefix[r_c];
        r_suf_rd <= m_suffix[r_c];
        r_stk_rd <= m_stack[r_sp[STACK_AW-1:0] - STACK_AW'(1)];
    end

    // next state
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (o_cmd_take && i_cmd.kind == REQ_PULL && !r_halt) begin
                    n_state = (r_sp != '0) ? S_POP : S_DECODE;
                end
            end
            // a clear code keeps decoding; any other code starts the walk unless it finishes the request
            S_DECODE: if (have_bits && {1'b0, code_now} != clr) n_state = S_READ;
            S_WALK:   n_state = ({1'b0, r_c} >= clr) ? S_READ : S_POP;
            S_READ:   n_state = S_WALK;
            S_POP:    n_state = S_DONE;
            S_DONE:   n_state = S_IDLE;
            default:  n_state = S_IDLE;
        endcase
        if (finish) n_state = S_IDLE;
    end

    // datapath and sequencing
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_acc   <= '0;
            r_held  <= '0;
            r_cw    <= 4'd9;
            r_free  <= (CW+1)'(258);
            r_limit <= (CW+1)'(512);
            r_first <= '0;
            r_prev  <= '0;
            r_await <= 1'b1;
            r_fin   <= 1'b0;
            r_halt  <= 1'b0;
            r_sp    <= '0;
            r_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (finish) begin
                r_valid <= 1'b1;
                r_pix   <= fin_pix;
                r_st    <= fin_st;
            end else if (r_valid && i_ready) begin
                r_valid <= 1'b0;
            end
            case (r_state)
                S_IDLE: begin
                    if (o_cmd_take) begin
                        case (i_cmd.kind)
                            REQ_FEED: begin
                                if (!r_halt && !r_fin) begin
                                    if (i_cmd.eod) r_fin <= 1'b1;
                                    else if (32'(r_held) + 32'd8 <= 32'(ACC_BITS)) begin
                                        r_acc  <= r_acc | (ACC_BITS'(i_cmd.data) << r_held);
                                        r_held <= r_held + HW'(8);
                                    end
                                end
                            end
                            REQ_PULL: ;
                            REQ_RESTART: begin
                                r_acc   <= '0;
                                r_held  <= '0;
                                r_first <= '0;
                                r_prev  <= '0;
                                r_await <= 1'b1;
                                r_fin   <= 1'b0;
                                r_halt  <= 1'b0;
                                r_cw    <= root + 4'd1;
                                r_free  <= clr + (CW+1)'(2);
                                r_limit <= clr << 1;
                                r_sp    <= '0;
                            end
                            default: ;
                        endcase
                    end
                end
                S_DECODE: begin
                    if (!have_bits) begin
                        if (r_fin) begin
                            r_halt <= 1'b1; r_await <= 1'b0; r_sp <= '0;
                        end
                    end else begin
                        r_acc  <= r_acc >> r_cw;
                        r_held <= r_held - HW'(r_cw);
                        r_code <= code_now;
                        if ({1'b0, code_now} == clr) begin
                            r_cw    <= root + 4'd1;
                            r_free  <= clr + (CW+1)'(2);
                            r_limit <= clr << 1;
                            r_sp    <= '0;
                            r_await <= 1'b1;
                        end else if ({1'b0, code_now} == clr + (CW+1)'(1)) begin
                            r_halt <= 1'b1; r_await <= 1'b0; r_sp <= '0;
                        end else if (r_await) begin
                            if ({1'b0, code_now} > clr) begin
                                r_halt <= 1'b1; r_sp <= '0;
                            end else begin
                                r_await <= 1'b0;
                                r_first <= code_now;
                                r_prev  <= code_now;
                            end
                        end else if ({1'b0, code_now} > r_free) begin
                            r_halt <= 1'b1; r_await <= 1'b1; r_sp <= '0;
                        end else begin
                            // code not yet in the table: lead with the first symbol
                            if ({1'b0, code_now} == r_free) begin
                                m_stack[r_sp[STACK_AW-1:0]] <= r_first[7:0];
                                r_sp <= r_sp + 1'b1;
                                r_c  <= r_prev;
                            end else begin
                                r_c <= code_now;
                            end
                        end
                    end
                end
                S_READ: ;
                S_WALK: begin
                    if ({1'b0, r_c} >= clr) begin
                        if (r_sp >= (STACK_AW+1)'(STACK_DEPTH) || r_pre_rd == r_c) begin
                            r_halt <= 1'b1; r_await <= 1'b1; r_sp <= '0;
                        end else begin
                            m_stack[r_sp[STACK_AW-1:0]] <= r_suf_rd;
                            r_sp <= r_sp + 1'b1;
                            r_c  <= r_pre_rd;
                        end
                    end else if (r_sp >= (STACK_AW+1)'(STACK_DEPTH)) begin
                        r_halt <= 1'b1; r_await <= 1'b1; r_sp <= '0;
                    end else begin
                        m_stack[r_sp[STACK_AW-1:0]] <= r_c[7:0];
                        r_sp    <= r_sp + 1'b1;
                        r_first <= r_c;
                        if (r_free < (CW+1)'(TSIZE)) begin
                            m_prefix[r_free[CW-1:0]] <= r_prev;
                            m_suffix[r_free[CW-1:0]] <= r_c[7:0];
                            r_free <= r_free + 1'b1;
                            if (r_free + 1'b1 >= r_limit && r_limit < (CW+1)'(TSIZE)) begin
                                r_limit <= r_limit << 1;
                                r_cw    <= r_cw + 4'd1;
                            end
                        end
                        r_prev  <= r_code;
                    end
                end
                S_POP: r_sp <= r_sp - 1'b1;
                default: ;
            endcase
        end
    end

    // result selection
    always_comb begin
        finish  = 1'b0;
        fin_st  = ST_OK;
        fin_pix = 8'd0;
        case (r_state)
            S_IDLE: begin
                if (o_cmd_take) begin
                    case (i_cmd.kind)
                        REQ_FEED: begin
                            finish = 1'b1;
                            if (!r_halt && !r_fin && !i_cmd.eod &&
                                32'(r_held) + 32'd8 > 32'(ACC_BITS)) fin_st = ST_FULL;
                        end
                        REQ_PULL: begin
                            if (r_halt) begin
                                finish = 1'b1;
                                fin_st = r_await ? ST_ERR : ST_END;
                            end
                        end
                        REQ_RESTART: finish = 1'b1;
                        default: begin finish = 1'b1; fin_st = ST_ERR; end
                    endcase
                end
            end
            S_DECODE: begin
                if (!have_bits) begin
                    finish = 1'b1;
                    fin_st = r_fin ? ST_END : ST_NEED;
                end else if ({1'b0, code_now} == clr + (CW+1)'(1)) begin
                    finish = 1'b1; fin_st = ST_END;
                end else if ({1'b0, code_now} != clr) begin
                    if (r_await) begin
                        finish = 1'b1;
                        fin_st = ({1'b0, code_now} > clr) ? ST_ERR : ST_PIXEL;
                        fin_pix = ({1'b0, code_now} > clr) ? 8'd0 : code_now[7:0];
                    end else if ({1'b0, code_now} > r_free) begin
                        finish = 1'b1; fin_st = ST_ERR;
                    end
                end
            end
            S_WALK: begin
                if (r_sp >= (STACK_AW+1)'(STACK_DEPTH) ||
                    ({1'b0, r_c} >= clr && r_pre_rd == r_c)) begin
                    finish = 1'b1; fin_st = ST_ERR;
                end
            end
            S_DONE: begin
                finish = 1'b1; fin_st = ST_PIXEL; fin_pix = r_stk_rd;
            end
            default: ;
        endcase
    end

endmodule
`default_nettype wire

>>> sv/gif_lzw_decoder_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// Feed, restart, bad and halted requests are answered from the idle state as the
// engine takes them; a pull from the stack passes the pop and done states. Each
// skipped clear code adds a decode step. A pull that ends in the decode step
// (first code, need data, end or bad code) answers from there; one that walks the
// table passes the read and walk states per entry walked. One request in the
// engine at a time. Synchronous active-low reset; tables are not cleared.
// ----------------------------------------------------------------------------
// gif_lzw_decoder_unit: GIF LZW pixel decoder
// Stream request in, stream result out, APB-style min code size register.
// ----------------------------------------------------------------------------
module gif_lzw_decoder_unit #(
    parameter int MAX_CODE_BITS = gld_pkg::MAX_CODE_BITS_DEF,
    parameter int ACC_BITS      = gld_pkg::ACC_BITS_DEF
) (
    input  wire         i_clk,
    input  wire         i_rst_n,
    input  wire         s_axis_tvalid,
    output logic        s_axis_tready,
    input  wire [7:0]   s_axis_tdata,   // [7:0] data_byte
    input  wire [2:0]   s_axis_tuser,   // [1:0] req_type, [2] end_of_data
    output logic        m_axis_tvalid,
    input  wire         m_axis_tready,
    output logic [7:0]  m_axis_tdata,   // [7:0] pixel_index
    output logic [2:0]  m_axis_tuser,   // [2:0] status
    input  wire         psel,
    input  wire         penable,
    input  wire         pwrite,
    input  wire [1:0]   paddr,
    input  wire [31:0]  pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import gld_pkg::*;

    localparam logic [1:0] ADDR_MCS = 2'd0;

    logic [3:0] r_mcs;
    logic       cmd_valid, cmd_take;
    t_cmd       cmd;

    assign pready = 1'b1;
    assign prdata = (paddr == ADDR_MCS) ? {28'd0, r_mcs} : 32'd0;

    // config register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_mcs <= 4'd8;
        end else if (psel && penable && pwrite && paddr == ADDR_MCS) begin
            r_mcs <= pwdata[3:0];
        end
    end

    gld_front u_front (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (s_axis_tvalid),
        .o_ready     (s_axis_tready),
        .i_kind      (s_axis_tuser[1:0]),
        .i_data      (s_axis_tdata),
        .i_eod       (s_axis_tuser[2]),
        .o_cmd_valid (cmd_valid),
        .i_cmd_take  (cmd_take),
        .o_cmd       (cmd)
    );

    gld_back #(
        .MAX_CODE_BITS (MAX_CODE_BITS),
        .ACC_BITS      (ACC_BITS)
    ) u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_cmd_valid     (cmd_valid),
        .o_cmd_take      (cmd_take),
        .i_cmd           (cmd),
        .i_min_code_size (r_mcs),
        .o_valid         (m_axis_tvalid),
        .i_ready         (m_axis_tready),
        .o_pixel         (m_axis_tdata),
        .o_status        (m_axis_tuser)
    );

    // a pixel result only carries a nonzero index when its status is pixel
    a_pix_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser != ST_PIXEL |-> m_axis_tdata == 8'd0)
        else $error("nonzero index on status result");

    // status codes stay in the defined set
    a_status: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid |-> m_axis_tuser <= ST_FULL)
        else $error("bad status");

    // a command is only taken when the result register can hold its answer
    a_take: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd_take |-> cmd_valid && (!m_axis_tvalid || m_axis_tready))
        else $error("take without room");

endmodule
`default_nettype wire
